### src/ppmhp_pkg.sv
// shared types, character codes and helper functions for the p6 header parser
// no dependencies
package ppmhp_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_WIDTH  = 3'd1,
    PH_HEIGHT = 3'd2,
    PH_MAXVAL = 3'd3,
    PH_PIXELS = 3'd4,
    PH_DRAIN  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    MAG_NONE = 2'd0,
    MAG_P    = 2'd1,
    MAG_P6   = 2'd2,
    MAG_BAD  = 2'd3
  } magic_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NOT_P6    = 2'd0,
    ERR_DIMENSION = 2'd1,
    ERR_MAXVAL    = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  pixel;
    logic        last;
    err_e        code;
  } result_t;

  localparam int unsigned NUM_W = 17;

  localparam logic [NUM_W-1:0] NUM_SATURATE    = 17'd65536;
  localparam logic [NUM_W-1:0] MAXVAL_REQUIRED = 17'd255;
  localparam logic [NUM_W-1:0] MAX_DIMENSION   = 17'd65535;

  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_SIX   = 8'h36;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic dim_ok(input logic [NUM_W-1:0] v);
    return (v != '0) && (v <= MAX_DIMENSION);
  endfunction

  // error reported when a phase is cut short
  function automatic err_e fail_code(input phase_e ph);
    err_e code;
    case (ph)
      PH_MAGIC:  code = ERR_NOT_P6;
      PH_WIDTH:  code = ERR_DIMENSION;
      PH_HEIGHT: code = ERR_DIMENSION;
      PH_MAXVAL: code = ERR_MAXVAL;
      default:   code = ERR_TRUNCATED;
    endcase
    return code;
  endfunction

endpackage

### src/ppmhp_parser.sv
// tokeniser, number reader and pixel counter: parser state and at most one result per byte
// depends on ppmhp_pkg
module ppmhp_parser
  import ppmhp_pkg::*;
#(
  parameter int unsigned TOKEN_CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_file_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int unsigned TL_W = $clog2(TOKEN_CAPACITY);

  phase_e            phase_q, phase_d;
  logic              comment_q, comment_d;
  logic [TL_W-1:0]   tl_q, tl_d;
  magic_e            mm_q, mm_d;
  logic [NUM_W-1:0]  nv_q, nv_d;
  logic              neg_q, neg_d;
  logic              ds_q, ds_d;
  logic [NUM_W-1:0]  width_q, width_d;
  logic [NUM_W-1:0]  height_q, height_d;
  logic [33:0]       pl_q, pl_d;

  logic [NUM_W-1:0]  num;
  logic              ok_magic;
  logic              fin_err;
  err_e              fin_code;
  logic              fin_hdr;
  phase_e            fin_phase;
  phase_e            eof_phase;
  logic              clear_tok;
  logic              take_tok;
  magic_e            tk_mm;
  logic [20:0]       acc;
  logic [NUM_W-1:0]  acc_sat;
  logic [31:0]       dim_product;
  logic [33:0]       pixels_start;
  logic [33:0]       pl_dec;

  assign num      = neg_q ? '0 : nv_q;
  assign ok_magic = (mm_q == MAG_P6) && (tl_q == TL_W'(2));

  // value * 10 + digit, saturating just above the largest dimension
  assign acc     = {1'b0, nv_q, 3'b000} + {3'b000, nv_q, 1'b0} + {17'd0, data_byte_i[3:0]};
  assign acc_sat = (acc > {4'd0, NUM_SATURATE}) ? NUM_SATURATE : acc[NUM_W-1:0];

  assign dim_product  = width_q[15:0] * height_q[15:0];
  assign pixels_start = {1'b0, dim_product, 1'b0} + {2'b00, dim_product};
  assign pl_dec       = pl_q - 34'd1;

  always_comb begin
    if (tl_q == '0 && data_byte_i == CHAR_P) begin
      tk_mm = MAG_P;
    end else if (tl_q == TL_W'(1) && mm_q == MAG_P && data_byte_i == CHAR_SIX) begin
      tk_mm = MAG_P6;
    end else begin
      tk_mm = MAG_BAD;
    end
  end

  // outcome of ending the current token
  always_comb begin
    fin_err   = 1'b0;
    fin_code  = ERR_NOT_P6;
    fin_hdr   = 1'b0;
    fin_phase = phase_q;
    case (phase_q)
      PH_MAGIC: begin
        if (ok_magic) begin
          fin_phase = PH_WIDTH;
        end else begin
          fin_err   = 1'b1;
          fin_code  = ERR_NOT_P6;
          fin_phase = PH_DRAIN;
        end
      end
      PH_WIDTH:  fin_phase = PH_HEIGHT;
      PH_HEIGHT: fin_phase = PH_MAXVAL;
      PH_MAXVAL: begin
        if (num != MAXVAL_REQUIRED) begin
          fin_err   = 1'b1;
          fin_code  = ERR_MAXVAL;
          fin_phase = PH_DRAIN;
        end else if (!dim_ok(width_q) || !dim_ok(height_q)) begin
          fin_err   = 1'b1;
          fin_code  = ERR_DIMENSION;
          fin_phase = PH_DRAIN;
        end else begin
          fin_hdr   = 1'b1;
          fin_phase = PH_PIXELS;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    comment_d  = comment_q;
    tl_d       = tl_q;
    mm_d       = mm_q;
    nv_d       = nv_q;
    neg_d      = neg_q;
    ds_d       = ds_q;
    width_d    = width_q;
    height_d   = height_q;
    pl_d       = pl_q;
    clear_tok  = 1'b0;
    take_tok   = 1'b0;
    eof_phase  = phase_q;
    res_valid_o  = 1'b0;
    res_o.kind   = KIND_ERROR;
    res_o.width  = '0;
    res_o.height = '0;
    res_o.pixel  = '0;
    res_o.last   = 1'b0;
    res_o.code   = ERR_NOT_P6;

    if (fire_i) begin
      if (end_of_file_i) begin
        // finish a token in progress first, then report what is missing
        if ((phase_q inside {PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL}) && tl_q != '0) begin
          if (fin_err) begin
            res_valid_o = 1'b1;
            res_o.code  = fin_code;
          end else begin
            eof_phase = fin_phase;
          end
        end
        if (!res_valid_o && eof_phase != PH_DRAIN) begin
          res_valid_o = 1'b1;
          res_o.code  = fail_code(eof_phase);
        end
        phase_d   = PH_MAGIC;
        comment_d = 1'b0;
        width_d   = '0;
        height_d  = '0;
        pl_d      = '0;
        clear_tok = 1'b1;
      end else begin
        case (phase_q)
          PH_PIXELS: begin
            pl_d         = pl_dec;
            res_valid_o  = 1'b1;
            res_o.kind   = KIND_PIXEL;
            res_o.pixel  = data_byte_i;
            res_o.last   = (pl_dec == '0);
            if (pl_dec == '0) begin
              phase_d = PH_DRAIN;
            end
          end
          PH_DRAIN: ;
          default: begin
            if (tl_q == '0) begin
              if (comment_q) begin
                if (data_byte_i == CHAR_NL) begin
                  comment_d = 1'b0;
                end
              end else if (data_byte_i == CHAR_HASH) begin
                comment_d = 1'b1;
              end else if (!is_ws(data_byte_i)) begin
                take_tok = 1'b1;
              end
            end else if (is_ws(data_byte_i)) begin
              clear_tok = 1'b1;
              phase_d   = fin_phase;
              if (phase_q == PH_WIDTH) begin
                width_d = num;
              end
              if (phase_q == PH_HEIGHT) begin
                height_d = num;
              end
              if (fin_err) begin
                res_valid_o = 1'b1;
                res_o.code  = fin_code;
              end else if (fin_hdr) begin
                pl_d         = pixels_start;
                res_valid_o  = 1'b1;
                res_o.kind   = KIND_HEADER;
                res_o.width  = width_q[15:0];
                res_o.height = height_q[15:0];
              end
            end else if (tl_q >= TL_W'(TOKEN_CAPACITY - 1)) begin
              // token overflow
              clear_tok   = 1'b1;
              phase_d     = PH_DRAIN;
              res_valid_o = 1'b1;
              res_o.code  = fail_code(phase_q);
            end else begin
              take_tok = 1'b1;
            end
          end
        endcase
      end
    end

    if (take_tok) begin
      mm_d = tk_mm;
      tl_d = tl_q + TL_W'(1);
      if (tl_q == '0 && (data_byte_i == CHAR_PLUS || data_byte_i == CHAR_MINUS)) begin
        neg_d = (data_byte_i == CHAR_MINUS);
      end else if (!ds_q && is_digit(data_byte_i)) begin
        nv_d = acc_sat;
      end else begin
        ds_d = 1'b1;
      end
    end

    if (clear_tok) begin
      tl_d  = '0;
      mm_d  = MAG_NONE;
      nv_d  = '0;
      neg_d = 1'b0;
      ds_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC;
      comment_q <= 1'b0;
      tl_q      <= '0;
      mm_q      <= MAG_NONE;
      nv_q      <= '0;
      neg_q     <= 1'b0;
      ds_q      <= 1'b0;
      width_q   <= '0;
      height_q  <= '0;
      pl_q      <= '0;
    end else begin
      phase_q   <= phase_d;
      comment_q <= comment_d;
      tl_q      <= tl_d;
      mm_q      <= mm_d;
      nv_q      <= nv_d;
      neg_q     <= neg_d;
      ds_q      <= ds_d;
      width_q   <= width_d;
      height_q  <= height_d;
      pl_q      <= pl_d;
    end
  end

endmodule

### src/ppmhp_out_reg.sv
// result register between the parser and the output channel
// depends on ppmhp_pkg
module ppmhp_out_reg
  import ppmhp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_ready_i,
  output logic    space_o,
  output logic    out_valid_o,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  // a new word may enter while the held one leaves in the same cycle
  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

### src/ppm_p6_header_parser_core.sv
// Binary PPM (P6) header parser with pixel pass-through.
// Input channel: one file byte per word (data_byte_i), or an end-of-file
// marker (end_of_file_i) that carries no byte and returns the parser to start.
// Output channel: at most one result word per input word - header accepted
// (width, height), pixel byte (with last_pixel_o on the final sample of
// width*height*3), or error (error_code_o). Unused result fields read zero.
// A result is registered and shown on out_valid_o the cycle after its input
// word is taken. Throughput: one input word per cycle while the receiver does
// not stall, set by the single parser state update and the one output register.
// If the receiver stalls with a result held, in_ready_o follows out_ready_i:
// the held word leaving frees room for the next one in the same cycle.
// Words that produce no result are taken whenever the output register has room.
// Reset puts the parser before the magic token with no result pending.
// depends on ppmhp_pkg, ppmhp_parser, ppmhp_out_reg
module ppm_p6_header_parser_core
  import ppmhp_pkg::*;
#(
  parameter int unsigned TOKEN_CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [7:0]  pixel_byte_o,
  output logic        last_pixel_o,
  output logic [1:0]  error_code_o
);

  logic    fire;
  logic    space;
  logic    res_valid;
  result_t res;
  result_t res_out;

  assign in_ready_o = space;
  assign fire       = in_valid_i && space;

  ppmhp_parser #(
    .TOKEN_CAPACITY(TOKEN_CAPACITY)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (data_byte_i),
    .end_of_file_i(end_of_file_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ppmhp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .out_ready_i(out_ready_i),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .res_o      (res_out)
  );

  assign result_kind_o  = res_out.kind;
  assign image_width_o  = res_out.width;
  assign image_height_o = res_out.height;
  assign pixel_byte_o   = res_out.pixel;
  assign last_pixel_o   = res_out.last;
  assign error_code_o   = res_out.code;

endmodule

### verif/tb_top.sv
// self-checking testbench for ppm_p6_header_parser_core: random p6 files, broken headers
// and noise go in byte by byte, results are checked against a behavioural parser
// depends on ppmhp_pkg and the rtl under src
import ppmhp_pkg::*;

class p6_stream_checker;
  localparam int unsigned TOKEN_LIMIT = 64;

  phase_e      phase;
  bit          in_cmt;
  int unsigned tok_len;
  magic_e      mag;
  bit [16:0]   num_val;
  bit          neg;
  bit          stopped;
  bit [16:0]   wd;
  bit [16:0]   ht;
  bit [33:0]   left;

  result_t     expected_words[$];
  int unsigned n_mismatch;

  function new();
    n_mismatch = 0;
    restart();
  endfunction

  function void clear_token();
    tok_len = 0;
    mag     = MAG_NONE;
    num_val = '0;
    neg     = 1'b0;
    stopped = 1'b0;
  endfunction

  function void restart();
    phase  = PH_MAGIC;
    in_cmt = 1'b0;
    wd     = '0;
    ht     = '0;
    left   = '0;
    clear_token();
  endfunction

  function bit is_blank(bit [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function bit dim_good(bit [16:0] v);
    return v >= 17'd1 && v <= 17'd65535;
  endfunction

  function err_e stop_code(phase_e ph);
    case (ph)
      PH_MAGIC:             return ERR_NOT_P6;
      PH_WIDTH, PH_HEIGHT:  return ERR_DIMENSION;
      PH_MAXVAL:            return ERR_MAXVAL;
      default:              return ERR_TRUNCATED;
    endcase
  endfunction

  function result_t error_word(err_e code);
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.code = code;
    return r;
  endfunction

  function result_t fail_word(err_e code);
    phase = PH_DRAIN;
    clear_token();
    return error_word(code);
  endfunction

  function void take_char(bit [7:0] c);
    int unsigned v;
    if (tok_len == 0 && c == CHAR_P)
      mag = MAG_P;
    else if (tok_len == 1 && mag == MAG_P && c == CHAR_SIX)
      mag = MAG_P6;
    else
      mag = MAG_BAD;
    if (tok_len == 0 && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
      neg = (c == CHAR_MINUS);
    end else if (!stopped && c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = num_val * 10 + (c - CHAR_ZERO);
      num_val = (v > 65536) ? 17'd65536 : v[16:0];
    end else begin
      stopped = 1'b1;
    end
    tok_len++;
  endfunction

  // closes the token in progress, returns 1 when it gives a result word
  function bit end_token(output result_t r);
    bit [16:0] val;
    bit        magic_ok;
    phase_e    ph;
    val      = neg ? 17'd0 : num_val;
    magic_ok = (mag == MAG_P6 && tok_len == 2);
    ph       = phase;
    r        = '0;
    clear_token();
    case (ph)
      PH_MAGIC: begin
        if (!magic_ok) begin
          r = fail_word(ERR_NOT_P6);
          return 1'b1;
        end
        phase = PH_WIDTH;
      end
      PH_WIDTH: begin
        wd    = val;
        phase = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        ht    = val;
        phase = PH_MAXVAL;
      end
      default: begin
        if (val != 17'd255) begin
          r = fail_word(ERR_MAXVAL);
          return 1'b1;
        end
        if (!dim_good(wd) || !dim_good(ht)) begin
          r = fail_word(ERR_DIMENSION);
          return 1'b1;
        end
        left     = {17'b0, wd} * {17'b0, ht} * 34'd3;
        phase    = PH_PIXELS;
        r.kind   = KIND_HEADER;
        r.width  = wd[15:0];
        r.height = ht[15:0];
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // returns 0 when the word is simply dropped while draining
  function bit note_word(bit [7:0] c, bit eof);
    result_t r;
    bit      got;
    if (eof) begin
      got = 1'b0;
      if (phase <= PH_MAXVAL && tok_len > 0)
        got = end_token(r) && r.kind == KIND_ERROR;
      if (!got && phase <= PH_PIXELS) begin
        r   = error_word(stop_code(phase));
        got = 1'b1;
      end
      if (got)
        expected_words.push_back(r);
      restart();
      return 1'b1;
    end
    if (phase == PH_DRAIN)
      return 1'b0;
    if (phase == PH_PIXELS) begin
      left    = left - 34'd1;
      r       = '0;
      r.kind  = KIND_PIXEL;
      r.pixel = c;
      r.last  = (left == 0);
      if (left == 0)
        phase = PH_DRAIN;
      expected_words.push_back(r);
      return 1'b1;
    end
    if (tok_len == 0) begin
      if (in_cmt) begin
        if (c == CHAR_NL)
          in_cmt = 1'b0;
      end else if (c == CHAR_HASH) begin
        in_cmt = 1'b1;
      end else if (!is_blank(c)) begin
        take_char(c);
      end
    end else if (is_blank(c)) begin
      if (end_token(r))
        expected_words.push_back(r);
    end else if (tok_len >= TOKEN_LIMIT - 1) begin
      expected_words.push_back(fail_word(stop_code(phase)));
    end else begin
      take_char(c);
    end
    return 1'b1;
  endfunction

  function string show(result_t r);
    return $sformatf("kind=%0d w=%0d h=%0d px=%02h last=%0b code=%0d",
                     r.kind, r.width, r.height, r.pixel, r.last, r.code);
  endfunction

  function void report(string what);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("[%0t] mismatch: %s", $time, what);
  endfunction

  function void check_word(result_t got);
    result_t exp;
    string   bad;
    if (expected_words.size() == 0) begin
      report({"unexpected word ", show(got)});
      return;
    end
    exp = expected_words.pop_front();
    bad = "";
    if (got.kind !== exp.kind)     bad = {bad, " kind"};
    if (got.width !== exp.width)   bad = {bad, " width"};
    if (got.height !== exp.height) bad = {bad, " height"};
    if (got.pixel !== exp.pixel)   bad = {bad, " pixel"};
    if (got.last !== exp.last)     bad = {bad, " last"};
    if (got.code !== exp.code)     bad = {bad, " code"};
    if (bad != "")
      report({"field", bad, ": expected ", show(exp), " got ", show(got)});
  endfunction

  function void check_leftover();
    while (expected_words.size() != 0)
      report({"never seen: ", show(expected_words.pop_front())});
  endfunction
endclass

module tb_top;
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        end_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic [7:0]  pixel_byte_o;
  logic        last_pixel_o;
  logic [1:0]  error_code_o;

  p6_stream_checker sb = new();

  bit [8:0]    file_q[$];
  int unsigned live_items = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycles = 0;

  ppm_p6_header_parser_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_file_i  (end_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .pixel_byte_o   (pixel_byte_o),
    .last_pixel_o   (last_pixel_o),
    .error_code_o   (error_code_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** ppm_p6_header_parser_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word(result_t'({result_kind_o, image_width_o, image_height_o,
                               pixel_byte_o, last_pixel_o, error_code_o}));
  end

  // receiver: random stalls, plus a long hold-off when asked for
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_word(input bit [7:0] b, input bit eof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (!in_ready_o);
    void'(sb.note_word(b, eof));
    live_items++;
    @(negedge clk_i);
  endtask

  task automatic send_file();
    foreach (file_q[i])
      send_word(file_q[i][7:0], file_q[i][8]);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.expected_words.size() != 0);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++)
      file_q.push_back({1'b0, s[i]});
  endfunction

  function automatic bit [7:0] pick_blank();
    case ($urandom_range(5))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      2:       return CHAR_NL;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return CHAR_CR;
    endcase
  endfunction

  // whitespace between tokens, now and then with a comment line
  function automatic void add_gap();
    bit [7:0] b;
    repeat ($urandom_range(1, 3))
      file_q.push_back({1'b0, pick_blank()});
    if ($urandom_range(7) == 0) begin
      file_q.push_back({1'b0, CHAR_HASH});
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom);
        if (b == CHAR_NL)
          b = CHAR_HASH;
        file_q.push_back({1'b0, b});
      end
      file_q.push_back({1'b0, CHAR_NL});
    end
  endfunction

  function automatic void add_number(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    case ($urandom_range(24))
      0:       s = {"-", s};
      1:       s = {"+", s};
      2:       s = {"00", s};
      3:       s = {s, "x"};
      4:       s = {s, "-7"};
      5:       s = {"-0", s};
      default: ;
    endcase
    add_text(s);
  endfunction

  // runs either side of the token length limit
  function automatic void add_long();
    repeat ($urandom_range(61, 66))
      file_q.push_back({1'b0, 8'h37});
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(39))
      0:       return 0;
      1:       return 65535;
      2:       return 65536;
      3:       return $urandom_range(65537, 250000);
      4:       return $urandom_range(5, 65534);
      5, 6:    return $urandom_range(3, 4);
      default: return $urandom_range(1, 2);
    endcase
  endfunction

  function automatic void build_file();
    int unsigned      style;
    int unsigned      long_at;
    int unsigned      wdv;
    int unsigned      htv;
    int unsigned      cut;
    longint unsigned  npix;
    file_q.delete();
    style   = $urandom_range(99);
    long_at = (style >= 10 && style < 20) ? $urandom_range(3) : 4;
    if (style < 10) begin
      repeat ($urandom_range(1, 20))
        file_q.push_back({1'b0, 8'($urandom)});
    end else begin
      if ($urandom_range(4) == 0)
        add_gap();
      if (long_at == 0)
        add_long();
      else
        case ($urandom_range(19))
          0:       add_text("P5");
          1:       add_text("P66");
          2:       add_text("p6");
          default: add_text("P6");
        endcase
      add_gap();
      wdv = pick_dim();
      if (long_at == 1) add_long(); else add_number(wdv);
      add_gap();
      htv = pick_dim();
      if (long_at == 2) add_long(); else add_number(htv);
      add_gap();
      if (long_at == 3)
        add_long();
      else
        add_number(($urandom_range(9) == 0) ? $urandom_range(0, 300) : 255);
      file_q.push_back({1'b0, pick_blank()});
      npix = wdv;
      npix = npix * htv * 3;
      if (npix > 150 || npix == 0)
        npix = $urandom_range(0, 12);
      else if ($urandom_range(3) == 0)
        npix = $urandom_range(0, 32'(npix - 1));
      else
        npix = npix + (($urandom_range(2) == 0) ? $urandom_range(1, 4) : 0);
      repeat (npix)
        file_q.push_back({1'b0, 8'($urandom)});
      if (style < 32) begin
        // end of file arrives early
        cut = $urandom_range(0, file_q.size());
        while (file_q.size() > cut)
          void'(file_q.pop_back());
      end else if (style < 40) begin
        cut = $urandom_range(0, (file_q.size() > 20) ? 19 : file_q.size() - 1);
        file_q[cut] = {1'b0, 8'($urandom)};
      end
    end
    file_q.push_back({1'b1, 8'($urandom)});
  endfunction

  initial begin
    bit       held;
    bit       paused;
    bit [7:0] tail_bytes[7];
    held   = 1'b0;
    paused = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 31;
    recv_idle_pct = 54;

    // every kind of blank but space, a comment, then a 1x2 image and one trailing byte
    file_q.delete();
    add_text("# hi\nP6\t1\0132\014255\015");
    tail_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0A, 8'h23, 8'h7E};
    foreach (tail_bytes[i])
      file_q.push_back({1'b0, tail_bytes[i]});
    file_q.push_back({1'b1, 8'hFF});
    send_file();
    // end of file with nothing, then right after a good magic token
    file_q.delete();
    file_q.push_back({1'b1, 8'h00});
    add_text("P6");
    file_q.push_back({1'b1, 8'h5A});
    send_file();

    while (live_items < 400) begin
      if ((live_items >= 270 && !paused) || $urandom_range(7) == 0) begin
        paused = paused || live_items >= 270;
        wait_drained();
      end
      if (live_items < 135) begin
        send_idle_pct = 31;
        recv_idle_pct = 54;
      end else if (live_items < 270) begin
        send_idle_pct = 54;
        recv_idle_pct = 31;
        if (!held) begin
          hold_cycles = 80;
          held        = 1'b1;
        end
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      build_file();
      send_file();
    end

    in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    sb.check_leftover();
    if (sb.n_mismatch == 0)
      $display("** ppm_p6_header_parser_core: PASSED **");
    else
      $display("** ppm_p6_header_parser_core: FAILED **");
    $finish;
  end
endmodule
